// File: rtl/drli_pkg.sv
// Shared types, widths and helper functions for the loop impedance block.
// Used by drli_front, drli_div_cell and distance_relay_loop_impedance.
`default_nettype none

package drli_pkg;

  localparam int COMP_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PHW        = 64;
  localparam int IM_LSB     = 32;
  localparam int VW         = COMP_WIDTH + 1;
  localparam int RW         = COMP_WIDTH + 2;
  localparam int KW         = COMP_WIDTH + RW;
  localparam int EW         = KW + 1;
  localparam int PW         = VW + COMP_WIDTH;
  localparam int NW         = PW + 1;
  localparam int DW         = 2 * COMP_WIDTH;

  localparam logic [2:0] LOOP_L1L2 = 3'd0;
  localparam logic [2:0] LOOP_L2L3 = 3'd1;
  localparam logic [2:0] LOOP_L3L1 = 3'd2;
  localparam logic [2:0] LOOP_L1E  = 3'd3;
  localparam logic [2:0] LOOP_L2E  = 3'd4;
  localparam logic [2:0] LOOP_L3E  = 3'd5;

  localparam logic [2:0] REG_EARTH_MODE  = 3'd0;
  localparam logic [2:0] REG_KL_REAL     = 3'd1;
  localparam logic [2:0] REG_KL_IMAG     = 3'd2;
  localparam logic [2:0] REG_KR_RATIO    = 3'd3;
  localparam logic [2:0] REG_KX_RATIO    = 3'd4;
  localparam logic [2:0] REG_MIN_CURRENT = 3'd5;

  typedef struct packed {
    logic [2:0]     loop_sel;
    logic [PHW-1:0] volt_one;
    logic [PHW-1:0] volt_two;
    logic [PHW-1:0] volt_three;
    logic [PHW-1:0] curr_one;
    logic [PHW-1:0] curr_two;
    logic [PHW-1:0] curr_three;
    logic           residual_given;
    logic [PHW-1:0] residual_in;
    logic [PHW-1:0] earth_in;
  } item_t;

  typedef struct packed {
    logic                         valid_res;
    logic signed [COMP_WIDTH-1:0] imp_real;
    logic signed [COMP_WIDTH-1:0] imp_imag;
    logic signed [COMP_WIDTH-1:0] meas_real;
    logic signed [COMP_WIDTH-1:0] meas_imag;
  } result_t;

  typedef struct packed {
    logic                         earth_mode;
    logic signed [COMP_WIDTH-1:0] kl_real;
    logic signed [COMP_WIDTH-1:0] kl_imag;
    logic signed [COMP_WIDTH-1:0] kr_ratio;
    logic signed [COMP_WIDTH-1:0] kx_ratio;
    logic [30:0]                  min_current;
  } cfg_t;

  // One word travelling down the divider chain: two quotient lanes share a divisor.
  typedef struct packed {
    logic                         ok;
    logic                         neg_re;
    logic                         neg_im;
    logic [DW-1:0]                den;
    logic [DW-1:0]                rem_re;
    logic [DW-1:0]                rem_im;
    logic [COMP_WIDTH-1:0]        bits_re;
    logic [COMP_WIDTH-1:0]        bits_im;
    logic signed [COMP_WIDTH-1:0] meas_re;
    logic signed [COMP_WIDTH-1:0] meas_im;
  } div_word_t;

  function automatic logic signed [COMP_WIDTH-1:0] ph_re(input logic [PHW-1:0] p);
    return p[COMP_WIDTH-1:0];
  endfunction

  function automatic logic signed [COMP_WIDTH-1:0] ph_im(input logic [PHW-1:0] p);
    return p[IM_LSB+COMP_WIDTH-1:IM_LSB];
  endfunction

  // True when the value lies in the signed component range.
  function automatic logic fits_comp(input logic [EW-1:0] v);
    return (&v[EW-1:COMP_WIDTH-1]) | ~(|v[EW-1:COMP_WIDTH-1]);
  endfunction

endpackage

`default_nettype wire

// File: rtl/drli_front.sv
// Front pipeline: loop selection, compensation, products and divider setup.
// Depends on drli_pkg; feeds the first drli_div_cell.
`default_nettype none

module drli_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               item_valid,
  input  wire drli_pkg::item_t    item,
  input  wire drli_pkg::cfg_t     cfg,
  output logic                    word_valid,
  output drli_pkg::div_word_t     word
);
  import drli_pkg::*;

  logic [DW-1:0] floor2;

  // stage 0
  logic  s0_valid;
  item_t s0;

  // stage 1
  logic signed [COMP_WIDTH-1:0] va_re, va_im, vb_re, vb_im, ca_re, ca_im, cb_re, cb_im;
  logic signed [RW-1:0] res_re, res_im, ie_re, ie_im, kb0, kb1, kb2, kb3;
  logic signed [COMP_WIDTH-1:0] ka0, ka1, ka2, ka3;
  logic sel_bad, sel_earth, sel_mode1;
  logic s1_valid, s1_bad, s1_earth, s1_mode1;
  logic signed [VW-1:0] s1_v_re, s1_v_im, s1_d_re, s1_d_im;
  logic signed [COMP_WIDTH-1:0] s1_c_re, s1_c_im;
  logic signed [KW-1:0] s1_m0, s1_m1, s1_m2, s1_m3;

  // stage 2
  logic signed [EW-1:0] pr, pi, tr, ti, ar, ai, br, bi;
  logic fit_ok;
  logic s2_valid, s2_ok;
  logic signed [VW-1:0] s2_v_re, s2_v_im;
  logic signed [COMP_WIDTH-1:0] s2_a_re, s2_a_im, s2_b_re, s2_b_im, s2_m_re, s2_m_im;

  // stage 3
  logic s3_valid, s3_ok;
  logic signed [PW-1:0] s3_p0, s3_p1, s3_p2, s3_p3, s3_p4, s3_p5;
  logic signed [COMP_WIDTH-1:0] s3_m_re, s3_m_im;

  // stage 4
  logic signed [NW-1:0] det;
  logic [NW-1:0] dmag;
  logic s4_valid, s4_ok, s4_dneg;
  logic [DW-1:0] s4_den;
  logic signed [NW-1:0] s4_n_re, s4_n_im;
  logic signed [COMP_WIDTH-1:0] s4_m_re, s4_m_im;

  // stage 5
  logic [NW-1:0] nabs_re, nabs_im, hi_re, hi_im;
  div_word_t word_next;

  always_comb begin
    sel_bad   = s0.loop_sel > LOOP_L3E;
    sel_earth = s0.loop_sel >= LOOP_L1E;
    sel_mode1 = sel_earth & cfg.earth_mode;
    va_re = ph_re(s0.volt_one);  va_im = ph_im(s0.volt_one);
    vb_re = ph_re(s0.volt_two);  vb_im = ph_im(s0.volt_two);
    ca_re = ph_re(s0.curr_one);  ca_im = ph_im(s0.curr_one);
    cb_re = ph_re(s0.curr_two);  cb_im = ph_im(s0.curr_two);
    unique case (s0.loop_sel)
      LOOP_L2L3: begin
        va_re = ph_re(s0.volt_two);   va_im = ph_im(s0.volt_two);
        vb_re = ph_re(s0.volt_three); vb_im = ph_im(s0.volt_three);
        ca_re = ph_re(s0.curr_two);   ca_im = ph_im(s0.curr_two);
        cb_re = ph_re(s0.curr_three); cb_im = ph_im(s0.curr_three);
      end
      LOOP_L3L1: begin
        va_re = ph_re(s0.volt_three); va_im = ph_im(s0.volt_three);
        vb_re = ph_re(s0.volt_one);   vb_im = ph_im(s0.volt_one);
        ca_re = ph_re(s0.curr_three); ca_im = ph_im(s0.curr_three);
        cb_re = ph_re(s0.curr_one);   cb_im = ph_im(s0.curr_one);
      end
      LOOP_L2E: begin
        va_re = ph_re(s0.volt_two);   va_im = ph_im(s0.volt_two);
        ca_re = ph_re(s0.curr_two);   ca_im = ph_im(s0.curr_two);
      end
      LOOP_L3E: begin
        va_re = ph_re(s0.volt_three); va_im = ph_im(s0.volt_three);
        ca_re = ph_re(s0.curr_three); ca_im = ph_im(s0.curr_three);
      end
      default: begin
      end
    endcase

    if (s0.residual_given) begin
      res_re = RW'(ph_re(s0.residual_in));
      res_im = RW'(ph_im(s0.residual_in));
    end else begin
      res_re = RW'(ph_re(s0.curr_one)) + RW'(ph_re(s0.curr_two)) + RW'(ph_re(s0.curr_three));
      res_im = RW'(ph_im(s0.curr_one)) + RW'(ph_im(s0.curr_two)) + RW'(ph_im(s0.curr_three));
    end
    ie_re = RW'(ph_re(s0.earth_in));
    ie_im = RW'(ph_im(s0.earth_in));

    // The four multipliers serve kL * IN in one mode and kr/kx * IE in the other.
    if (sel_mode1) begin
      ka0 = cfg.kr_ratio; kb0 = ie_re;
      ka1 = cfg.kr_ratio; kb1 = ie_im;
      ka2 = cfg.kx_ratio; kb2 = ie_re;
      ka3 = cfg.kx_ratio; kb3 = ie_im;
    end else begin
      ka0 = cfg.kl_real;  kb0 = res_re;
      ka1 = cfg.kl_imag;  kb1 = res_im;
      ka2 = cfg.kl_real;  kb2 = res_im;
      ka3 = cfg.kl_imag;  kb3 = res_re;
    end
  end

  always_comb begin
    pr = (EW'(s1_m0) - EW'(s1_m1)) >>> FRAC_BITS;
    pi = (EW'(s1_m2) + EW'(s1_m3)) >>> FRAC_BITS;
    tr = EW'(s1_c_re) + pr;
    ti = EW'(s1_c_im) + pi;
    ar = EW'(s1_c_re) - EW'(s1_m0 >>> FRAC_BITS);
    ai = EW'(s1_c_im) - EW'(s1_m1 >>> FRAC_BITS);
    br = EW'(s1_c_re) - EW'(s1_m2 >>> FRAC_BITS);
    bi = EW'(s1_c_im) - EW'(s1_m3 >>> FRAC_BITS);
    if (s1_mode1) begin
      fit_ok = fits_comp(ar) & fits_comp(ai) & fits_comp(br) & fits_comp(bi);
    end else if (s1_earth) begin
      fit_ok = fits_comp(tr) & fits_comp(ti);
      ar = tr; ai = ti; br = tr; bi = ti;
    end else begin
      fit_ok = fits_comp(EW'(s1_d_re)) & fits_comp(EW'(s1_d_im));
      ar = EW'(s1_d_re); ai = EW'(s1_d_im); br = ar; bi = ai;
    end
  end

  always_comb begin
    det     = NW'(s3_p0) + NW'(s3_p1);
    dmag    = det[NW-1] ? -det : det;
    nabs_re = s4_n_re[NW-1] ? -s4_n_re : s4_n_re;
    nabs_im = s4_n_im[NW-1] ? -s4_n_im : s4_n_im;
    hi_re   = nabs_re >> (COMP_WIDTH - FRAC_BITS);
    hi_im   = nabs_im >> (COMP_WIDTH - FRAC_BITS);
    // A quotient that needs more than COMP_WIDTH bits is refused before the chain.
    word_next.ok      = s4_ok & (hi_re < NW'(s4_den)) & (hi_im < NW'(s4_den));
    word_next.neg_re  = s4_n_re[NW-1] ^ s4_dneg;
    word_next.neg_im  = s4_n_im[NW-1] ^ s4_dneg;
    word_next.den     = s4_den;
    word_next.rem_re  = hi_re[DW-1:0];
    word_next.rem_im  = hi_im[DW-1:0];
    word_next.bits_re = {nabs_re[COMP_WIDTH-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
    word_next.bits_im = {nabs_im[COMP_WIDTH-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
    word_next.meas_re = s4_m_re;
    word_next.meas_im = s4_m_im;
  end

  always_ff @(posedge clk) begin
    floor2 <= DW'(cfg.min_current) * DW'(cfg.min_current);
    if (rst) begin
      s0_valid   <= 1'b0;
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      s3_valid   <= 1'b0;
      s4_valid   <= 1'b0;
      word_valid <= 1'b0;
    end else if (en) begin
      s0_valid   <= item_valid;
      s1_valid   <= s0_valid;
      s2_valid   <= s1_valid;
      s3_valid   <= s2_valid;
      s4_valid   <= s3_valid;
      word_valid <= s4_valid;
    end
    if (en) begin
      s0 <= item;

      s1_bad   <= sel_bad;
      s1_earth <= sel_earth;
      s1_mode1 <= sel_mode1;
      s1_v_re  <= sel_earth ? VW'(va_re) : VW'(va_re) - VW'(vb_re);
      s1_v_im  <= sel_earth ? VW'(va_im) : VW'(va_im) - VW'(vb_im);
      s1_d_re  <= VW'(ca_re) - VW'(cb_re);
      s1_d_im  <= VW'(ca_im) - VW'(cb_im);
      s1_c_re  <= ca_re;
      s1_c_im  <= ca_im;
      s1_m0    <= KW'(ka0) * KW'(kb0);
      s1_m1    <= KW'(ka1) * KW'(kb1);
      s1_m2    <= KW'(ka2) * KW'(kb2);
      s1_m3    <= KW'(ka3) * KW'(kb3);

      s2_ok   <= ~s1_bad & fit_ok;
      s2_v_re <= s1_v_re;
      s2_v_im <= s1_v_im;
      s2_a_re <= ar[COMP_WIDTH-1:0];
      s2_a_im <= ai[COMP_WIDTH-1:0];
      s2_b_re <= br[COMP_WIDTH-1:0];
      s2_b_im <= bi[COMP_WIDTH-1:0];
      s2_m_re <= s1_mode1 ? s1_c_re : ar[COMP_WIDTH-1:0];
      s2_m_im <= s1_mode1 ? s1_c_im : ai[COMP_WIDTH-1:0];

      // Outside the kr/kx case both a and b hold the measuring current.
      s3_ok   <= s2_ok;
      s3_p0   <= PW'(s2_a_re) * PW'(s2_b_re);
      s3_p1   <= PW'(s2_a_im) * PW'(s2_b_im);
      s3_p2   <= PW'(s2_v_re) * PW'(s2_b_re);
      s3_p3   <= PW'(s2_v_im) * PW'(s2_b_im);
      s3_p4   <= PW'(s2_v_im) * PW'(s2_a_re);
      s3_p5   <= PW'(s2_v_re) * PW'(s2_a_im);
      s3_m_re <= s2_m_re;
      s3_m_im <= s2_m_im;

      s4_ok   <= s3_ok & (dmag[DW-1:0] > floor2);
      s4_dneg <= det[NW-1];
      s4_den  <= dmag[DW-1:0];
      s4_n_re <= NW'(s3_p2) + NW'(s3_p3);
      s4_n_im <= NW'(s3_p4) - NW'(s3_p5);
      s4_m_re <= s3_m_re;
      s4_m_im <= s3_m_im;

      word <= word_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/drli_div_cell.sv
// One restoring-division step for both quotient lanes of a chain word.
// Depends on drli_pkg; instantiated COMP_WIDTH times by the top level.
`default_nettype none

module drli_div_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               word_in_valid,
  input  wire drli_pkg::div_word_t word_in,
  output logic                    word_out_valid,
  output drli_pkg::div_word_t     word_out
);
  import drli_pkg::*;

  logic [DW:0] trial_re, trial_im;
  logic        ge_re, ge_im;
  div_word_t   word_next;

  always_comb begin
    trial_re = {word_in.rem_re, word_in.bits_re[COMP_WIDTH-1]};
    trial_im = {word_in.rem_im, word_in.bits_im[COMP_WIDTH-1]};
    ge_re    = trial_re >= {1'b0, word_in.den};
    ge_im    = trial_im >= {1'b0, word_in.den};
    word_next = word_in;
    // Dividend bits leave at the top while quotient bits enter at the bottom.
    word_next.rem_re  = ge_re ? DW'(trial_re - {1'b0, word_in.den}) : trial_re[DW-1:0];
    word_next.rem_im  = ge_im ? DW'(trial_im - {1'b0, word_in.den}) : trial_im[DW-1:0];
    word_next.bits_re = {word_in.bits_re[COMP_WIDTH-2:0], ge_re};
    word_next.bits_im = {word_in.bits_im[COMP_WIDTH-2:0], ge_im};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_out_valid <= 1'b0;
    end else if (en) begin
      word_out_valid <= word_in_valid;
    end
    if (en) begin
      word_out <= word_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/distance_relay_loop_impedance.sv
// Distance relay loop impedance: register port, pipeline, divider chain, output skid.
// Depends on drli_pkg, drli_front and drli_div_cell.
//
// Usage: an input word (loop selector, three voltage and three current phasors,
// residual and earth currents) enters on item_valid/item_ready. One result word
// (valid_res, impedance, measuring current) leaves on result_valid/result_ready
// for every input word, in order; refused loops give valid_res low and zero fields.
// Throughput is one word per cycle while the receiver does not stall. An input
// word passes an input register, five arithmetic stages, one divider cell per
// quotient bit (COMP_WIDTH cells) and the output register: 39 register stages,
// the first loaded as the word is taken. The divider chain sets the latency.
// When the receiver stalls, one more result is caught in a skid register, then
// item_ready drops and the whole pipeline holds until the receiver takes a word.
// Reset empties the pipeline and restores the registers (all zero, min_current 1).
// Registers are written through the APB port at byte address 4*index and may only
// change while no word is in flight.
`default_nettype none

module distance_relay_loop_impedance (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [4:0]       paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  wire logic             item_valid,
  output logic                  item_ready,
  input  wire drli_pkg::item_t  item,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output drli_pkg::result_t     result
);
  import drli_pkg::*;

  cfg_t       cfg;
  logic       en;
  logic       front_valid;
  div_word_t  front_word;
  logic       chain_valid [COMP_WIDTH+1];
  div_word_t  chain_word [COMP_WIDTH+1];
  div_word_t  last;
  logic       lim_re, lim_im, all_ok;
  result_t    res_next;
  logic       skid_full;
  result_t    skid;
  logic       take, arrive;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.earth_mode  <= 1'b0;
      cfg.kl_real     <= '0;
      cfg.kl_imag     <= '0;
      cfg.kr_ratio    <= '0;
      cfg.kx_ratio    <= '0;
      cfg.min_current <= 31'd1;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_EARTH_MODE:  cfg.earth_mode  <= pwdata[0];
        REG_KL_REAL:     cfg.kl_real     <= pwdata;
        REG_KL_IMAG:     cfg.kl_imag     <= pwdata;
        REG_KR_RATIO:    cfg.kr_ratio    <= pwdata;
        REG_KX_RATIO:    cfg.kx_ratio    <= pwdata;
        REG_MIN_CURRENT: cfg.min_current <= pwdata[30:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_EARTH_MODE:  prdata = {31'd0, cfg.earth_mode};
      REG_KL_REAL:     prdata = cfg.kl_real;
      REG_KL_IMAG:     prdata = cfg.kl_imag;
      REG_KR_RATIO:    prdata = cfg.kr_ratio;
      REG_KX_RATIO:    prdata = cfg.kx_ratio;
      REG_MIN_CURRENT: prdata = {1'b0, cfg.min_current};
      default:         prdata = '0;
    endcase
  end

  assign en         = ~skid_full;
  assign item_ready = en;

  drli_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .item_valid (item_valid),
    .item       (item),
    .cfg        (cfg),
    .word_valid (front_valid),
    .word       (front_word)
  );

  assign chain_valid[0] = front_valid;
  assign chain_word[0]  = front_word;

  for (genvar i = 0; i < COMP_WIDTH; i++) begin : g_cell
    drli_div_cell u_cell (
      .clk            (clk),
      .rst            (rst),
      .en             (en),
      .word_in_valid  (chain_valid[i]),
      .word_in        (chain_word[i]),
      .word_out_valid (chain_valid[i+1]),
      .word_out       (chain_word[i+1])
    );
  end

  always_comb begin
    last   = chain_word[COMP_WIDTH];
    // A negative quotient may reach one step further than a positive one.
    lim_re = ~last.bits_re[COMP_WIDTH-1]
             | (last.neg_re & ~(|last.bits_re[COMP_WIDTH-2:0]));
    lim_im = ~last.bits_im[COMP_WIDTH-1]
             | (last.neg_im & ~(|last.bits_im[COMP_WIDTH-2:0]));
    all_ok = last.ok & lim_re & lim_im;
    res_next.valid_res = all_ok;
    res_next.imp_real  = '0;
    res_next.imp_imag  = '0;
    res_next.meas_real = '0;
    res_next.meas_imag = '0;
    if (all_ok) begin
      res_next.imp_real  = last.neg_re ? -last.bits_re : last.bits_re;
      res_next.imp_imag  = last.neg_im ? -last.bits_im : last.bits_im;
      res_next.meas_real = last.meas_re;
      res_next.meas_imag = last.meas_im;
    end
  end

  assign take   = result_valid & result_ready;
  assign arrive = chain_valid[COMP_WIDTH] & en;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_full    <= 1'b0;
    end else if (skid_full) begin
      if (take) begin
        result_valid <= 1'b1;
        skid_full    <= 1'b0;
      end
    end else if (!result_valid || take) begin
      result_valid <= arrive;
    end else if (arrive) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (take) begin
        result <= skid;
      end
    end else if (!result_valid || take) begin
      result <= res_next;
    end else if (arrive) begin
      skid <= res_next;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> result_valid)
    else $error("skid register holds a word while the output register is empty");

  a_skid_on_stall: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_full) |-> $past(result_valid && !result_ready))
    else $error("skid register filled without a stalled output");

  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.valid_res) |->
      (result.imp_real == 0 && result.imp_imag == 0
       && result.meas_real == 0 && result.meas_imag == 0))
    else $error("refused result carries nonzero fields");

  a_chain_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(chain_valid[COMP_WIDTH]))
    else $error("divider chain moved while the pipeline was held");

endmodule

`default_nettype wire
